[hw/rtl/vsc_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants for the vehicle speed conditioner.
// No dependencies; imported by vehicle_speed_conditioner_unit.

package vsc_pkg;

   localparam int RAW_W    = 13;
   localparam int SPEED_W  = 13;
   localparam int HOLD_W   = 8;
   localparam int DISP_W   = 9;
   localparam int CSR_AW   = 3;
   localparam int CSR_DW   = 13;
   localparam int REQ_DW   = 16;
   localparam int RSP_DW   = 40;

   localparam logic [RAW_W-1:0]   RAW_ERROR_MIN  = 13'h1FFE;
   localparam logic [SPEED_W-1:0] OUT_ERROR_CODE = 13'h1FFF;
   localparam logic [RAW_W-1:0]   LOW_SPEED_RAW  = 13'd10;
   localparam logic [RAW_W-1:0]   CAL_KNEE_RAW   = 13'd355;
   localparam logic [19:0]        CAL_MUL        = 20'd103;
   localparam logic [19:0]        CAL_OFFSET     = 20'd2222;
   // ceil(2^23 / 25): exact quotient for dividends below 2^18
   localparam logic [36:0]        RECIP_25       = 37'd335545;
   localparam int                 RECIP_25_SH    = 23;
   // ceil(2^16 / 5): exact quotient for dividends below 2^12
   localparam logic [25:0]        RECIP_5        = 26'd13108;
   localparam logic [16:0]        CEIL_160_BIAS  = 17'd159;

   localparam logic [SPEED_W-1:0] SPEED_CAP_RST   = 13'd4606;
   localparam logic [RAW_W-1:0]   RUN_ON_RST      = 13'd44;
   localparam logic [RAW_W-1:0]   RUN_OFF_RST     = 13'd36;
   localparam logic [HOLD_W-1:0]  HOLD_TICKS_RST  = 8'd200;
   localparam logic [SPEED_W-1:0] OUT_CAP_RST     = 13'h10AB;

   typedef enum logic [1:0] {
      CMD_TICK     = 2'd0,
      CMD_STANDBY  = 2'd1,
      CMD_IGN_INIT = 2'd2
   } cmd_type;

   typedef enum logic [CSR_AW-1:0] {
      CSR_SPEED_CAP   = 3'd0,
      CSR_RUN_ON_RAW  = 3'd1,
      CSR_RUN_OFF_RAW = 3'd2,
      CSR_HOLD_TICKS  = 3'd3,
      CSR_OUT_CAP     = 3'd4
   } csr_index_type;

   typedef enum logic [1:0] {
      DISP_HOLD,
      DISP_ZERO,
      DISP_FLOOR,
      DISP_CEIL
   } disp_mode_type;

endpackage

[hw/rtl/vehicle_speed_conditioner_unit.sv]
`timescale 1ns / 1ps
// Vehicle speed conditioner: raw CAN speed to tenths, running flag,
// calibrated outgoing speed and display km/h. Depends on vsc_pkg.

// Usage
//  - req channel: tuser carries the command (tick, standby, ignition
//    init); tdata carries raw speed and the three status bits.
//  - rsp channel: one result per request, in request order, holding the
//    four conditioned values after that request.
//  - csr port: single-cycle writes of the five calibration registers,
//    allowed only while no request is in flight.
//  Timing: a request enters an input register, the state register then
//  updates the conditioning state (two chained constant multiplies),
//  and the result register then loads with the display value. One
//  request per cycle is sustained while rsp_tready stays high.
//  Reset: synchronous; valid flags and conditioning state clear,
//  calibration registers load their defaults, no result is pending.
//  Stall: while rsp_tready is low the result register holds and the
//  two stages behind it keep filling, so req_tready drops only once
//  all three stages are full.

module vehicle_speed_conditioner_unit
   import vsc_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   // [12:0] can_speed, [13] signal_present, [14] invalid_flag,
   // [15] ign_elapsed
   input  logic [REQ_DW-1:0] req_tdata,
   // [1:0] cmd
   input  logic [1:0]        req_tuser,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   // [12:0] speed_tenths, [13] running, [26:14] out_speed,
   // [35:27] display_kmh, [39:36] zero
   output logic [RSP_DW-1:0] rsp_tdata,
   input  logic              csr_we,
   input  logic [CSR_AW-1:0] csr_addr,
   input  logic [CSR_DW-1:0] csr_wdata
);

   // calibration registers
   logic [SPEED_W-1:0] speed_cap_ff, out_cap_ff;
   logic [RAW_W-1:0]   run_on_ff, run_off_ff;
   logic [HOLD_W-1:0]  hold_ticks_ff;

   // input stage
   logic             a_valid_ff;
   logic [1:0]       a_cmd_ff;
   logic [RAW_W-1:0] a_raw_ff;
   logic             a_present_ff, a_invalid_ff, a_ign_ff;

   // state stage
   logic               b_valid_ff;
   logic [SPEED_W-1:0] speed_ff, speed_in;
   logic               running_ff, running_in;
   logic [HOLD_W-1:0]  hold_ff, hold_in;
   logic [SPEED_W-1:0] out_speed_ff, out_speed_in;
   disp_mode_type      disp_mode_ff, disp_mode_in;

   // result stage
   logic               c_valid_ff;
   logic [SPEED_W-1:0] c_speed_ff, c_out_speed_ff;
   logic               c_running_ff;
   logic [DISP_W-1:0]  display_ff, display_in;

   logic a_en, b_en, c_en;

   // datapath of the state stage
   logic               err, good, knee, low;
   logic [16:0]        spd_x9;
   logic [SPEED_W-1:0] spd_round;
   logic [19:0]        cal_x103, cal_num;
   logic [36:0]        cal_prod;
   logic [13:0]        cal_q, cal_t;
   logic [SPEED_W-1:0] cal_out;

   // datapath of the result stage
   logic [16:0] dsp_x9, dsp_sum;
   logic [11:0] dsp_div32;
   logic [25:0] dsp_prod;

   // ---------------------------------------------------------------
   // Flow control: each stage advances when the one ahead frees up.
   // ---------------------------------------------------------------
   assign c_en       = !c_valid_ff || rsp_tready;
   assign b_en       = !b_valid_ff || c_en;
   assign a_en       = !a_valid_ff || b_en;
   assign req_tready = a_en;

   // ---------------------------------------------------------------
   // Calibration registers
   // ---------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         speed_cap_ff  <= SPEED_CAP_RST;
         run_on_ff     <= RUN_ON_RST;
         run_off_ff    <= RUN_OFF_RST;
         hold_ticks_ff <= HOLD_TICKS_RST;
         out_cap_ff    <= OUT_CAP_RST;
      end else if (csr_we) begin
         unique case (csr_addr)
            CSR_SPEED_CAP:   speed_cap_ff  <= csr_wdata;
            CSR_RUN_ON_RAW:  run_on_ff     <= csr_wdata;
            CSR_RUN_OFF_RAW: run_off_ff    <= csr_wdata;
            CSR_HOLD_TICKS:  hold_ticks_ff <= csr_wdata[HOLD_W-1:0];
            CSR_OUT_CAP:     out_cap_ff    <= csr_wdata;
            default:         ;
         endcase
      end
   end

   // ---------------------------------------------------------------
   // Input register
   // ---------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (a_en) begin
         a_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (a_en && req_tvalid) begin
         a_cmd_ff     <= req_tuser;
         a_raw_ff     <= req_tdata[RAW_W-1:0];
         a_present_ff <= req_tdata[13];
         a_invalid_ff <= req_tdata[14];
         a_ign_ff     <= req_tdata[15];
      end
   end

   // ---------------------------------------------------------------
   // Conditioning arithmetic
   // ---------------------------------------------------------------
   always_comb begin
      err  = a_raw_ff >= RAW_ERROR_MIN;
      good = a_present_ff && !a_invalid_ff && !err;
      knee = a_raw_ff > CAL_KNEE_RAW;
      low  = a_raw_ff < LOW_SPEED_RAW;

      // raw * 0.5625 = raw * 9 / 16, rounded half up
      spd_x9    = 17'({a_raw_ff, 3'b000}) + 17'(a_raw_ff) + 17'd8;
      spd_round = spd_x9[16:4];

      // raw * 1.03 with knee offset; divide by 100 as /4 then /25
      cal_x103 = 20'(a_raw_ff) * CAL_MUL;
      cal_num  = knee ? cal_x103 + CAL_OFFSET : cal_x103;
      cal_prod = 37'(cal_num[19:2]) * RECIP_25;
      cal_q    = cal_prod[RECIP_25_SH +: 14];
      cal_t    = knee ? cal_q : cal_q + 14'd1;
      if (low) begin
         cal_out = '0;
      end else if (cal_t >= {1'b0, out_cap_ff}) begin
         cal_out = out_cap_ff;
      end else begin
         cal_out = cal_t[SPEED_W-1:0];
      end
   end

   // ---------------------------------------------------------------
   // Next state per command
   // ---------------------------------------------------------------
   always_comb begin
      speed_in     = speed_ff;
      running_in   = running_ff;
      hold_in      = hold_ff;
      out_speed_in = out_speed_ff;
      disp_mode_in = DISP_HOLD;

      unique case (a_cmd_ff)
         CMD_TICK: begin
            speed_in = '0;
            if (a_ign_ff && good) begin
               speed_in = (spd_round > speed_cap_ff) ? speed_cap_ff : spd_round;
            end

            priority if (!good) begin
               running_in = 1'b0;
            end else if (a_raw_ff > run_on_ff) begin
               running_in = 1'b1;
            end else if (a_raw_ff < run_off_ff) begin
               running_in = 1'b0;
            end else begin
               // inside the dead band: hold the flag
               running_in = running_ff;
            end

            priority if (!a_present_ff) begin
               out_speed_in = '0;
               hold_in      = '0;
            end else if (err) begin
               out_speed_in = OUT_ERROR_CODE;
               hold_in      = '0;
            end else if (a_invalid_ff) begin
               // count up the hold, then flag the error
               if (hold_ff < hold_ticks_ff) begin
                  hold_in = hold_ff + 8'd1;
               end else begin
                  out_speed_in = OUT_ERROR_CODE;
               end
            end else begin
               hold_in      = '0;
               out_speed_in = cal_out;
            end

            if (!good || low) begin
               disp_mode_in = DISP_ZERO;
            end else begin
               disp_mode_in = knee ? DISP_FLOOR : DISP_CEIL;
            end
         end
         CMD_STANDBY: begin
            speed_in     = '0;
            running_in   = 1'b0;
            out_speed_in = '0;
            disp_mode_in = DISP_ZERO;
         end
         CMD_IGN_INIT: begin
            speed_in     = '0;
            running_in   = 1'b0;
            out_speed_in = '0;
            hold_in      = '0;
            disp_mode_in = DISP_ZERO;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff   <= 1'b0;
         speed_ff     <= '0;
         running_ff   <= 1'b0;
         hold_ff      <= '0;
         out_speed_ff <= '0;
         disp_mode_ff <= DISP_ZERO;
      end else if (b_en) begin
         b_valid_ff <= a_valid_ff;
         if (a_valid_ff) begin
            speed_ff     <= speed_in;
            running_ff   <= running_in;
            hold_ff      <= hold_in;
            out_speed_ff <= out_speed_in;
            disp_mode_ff <= disp_mode_in;
         end
      end
   end

   // ---------------------------------------------------------------
   // Display: out_speed * 5625 / 100000 = out_speed * 9 / 160
   // ---------------------------------------------------------------
   always_comb begin
      dsp_x9    = 17'({out_speed_ff, 3'b000}) + 17'(out_speed_ff);
      dsp_sum   = (disp_mode_ff == DISP_CEIL) ? dsp_x9 + CEIL_160_BIAS : dsp_x9;
      dsp_div32 = dsp_sum[16:5];
      dsp_prod  = 26'(dsp_div32) * RECIP_5;

      unique case (disp_mode_ff)
         DISP_ZERO:  display_in = '0;
         DISP_FLOOR,
         DISP_CEIL:  display_in = dsp_prod[16 +: DISP_W];
         default:    display_in = display_ff;
      endcase
   end

   // ---------------------------------------------------------------
   // Result register
   // ---------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         c_valid_ff <= 1'b0;
         display_ff <= '0;
      end else if (c_en) begin
         c_valid_ff <= b_valid_ff;
         if (b_valid_ff) begin
            display_ff <= display_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (c_en && b_valid_ff) begin
         c_speed_ff     <= speed_ff;
         c_running_ff   <= running_ff;
         c_out_speed_ff <= out_speed_ff;
      end
   end

   assign rsp_tvalid = c_valid_ff;
   assign rsp_tdata  = {4'b0000, display_ff, c_out_speed_ff, c_running_ff, c_speed_ff};

endmodule
